@@ rtl/base58_encoder_top_macros.svh @@
// Assertion helpers shared by the encoder RTL.
`ifndef BASE58_ENCODER_TOP_MACROS_SVH
`define BASE58_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B58E_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define B58E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/b58e_pkg.sv @@
package b58e_pkg;

	localparam int MAX_BYTES_DEF = 32;
	localparam int RADIX         = 58;
	localparam int DIGIT_W       = 6;
	localparam int CARRY_W       = 9;
	localparam int VAL_W         = 14;
	localparam int SYM_W         = 7;
	// v / 58 == (v * RECIP) >> RECIP_SHIFT for every v below 2**VAL_W
	localparam int RECIP         = 1157050;
	localparam int RECIP_SHIFT   = 26;
	localparam int PROD_W        = RECIP_SHIFT + CARRY_W;

	localparam logic [SYM_W-1:0] CHAR_ONE = 7'h31;

	localparam logic [SYM_W-1:0] ALPHABET [RADIX] = '{
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
		7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
		7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E,
		7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
		7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69, 7'h6A, 7'h6B,
		7'h6D, 7'h6E, 7'h6F, 7'h70, 7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77,
		7'h78, 7'h79, 7'h7A
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_ONES,
		ST_DIGITS
	} state_t;

	// carry wave between neighboring cells
	typedef struct packed {
		logic               vld;
		logic [CARRY_W-1:0] carry;
	} link_t;

	// digit slot as it moves up the row during readout
	typedef struct packed {
		logic               used;
		logic [DIGIT_W-1:0] digit;
	} slot_t;

	typedef struct packed {
		logic shift;
		logic restart;
	} ctl_t;

	function automatic logic [SYM_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
		logic [SYM_W-1:0] c;
		c = CHAR_ONE;
		if (d < DIGIT_W'(RADIX)) begin
			c = ALPHABET[d];
		end
		return c;
	endfunction

endpackage

@@ rtl/base58_encoder_top.sv @@
// Base58 encoder, Bitcoin alphabet. Bytes arrive most significant first, one beat per byte,
// tlast on the final byte; the encoding leaves as ASCII characters, tlast on the final one.
// While a message is coming in, a byte is taken every cycle: each byte launches a carry wave
// that walks the row of DIGIT_DEPTH = MAX_BYTES*138/100+1 digit cells (45 at the default),
// one cell per cycle, so several waves are in flight at once. After the final byte the row
// drains until no carry wave is left in flight. Then one character per cycle, while the output
// is not stalled, is sent for each leading zero byte, and the digits shift out of the top cell,
// one cell per cycle while the output is not stalled (empty high cells are skipped without a
// character). Bytes beyond MAX_BYTES are dropped, but their tlast still ends the message.
`include "base58_encoder_top_macros.svh"

module base58_encoder_top #(
	parameter int MAX_BYTES = b58e_pkg::MAX_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [6:0] symbol, [7] zero
	output logic       m_tlast
);

	localparam int DIGIT_DEPTH = (MAX_BYTES * 138) / 100 + 1;
	localparam int CNT_W       = $clog2(MAX_BYTES + 1);

	b58e_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] byte_cnt_q;
	logic [CNT_W-1:0] zero_cnt_q;
	logic             in_zero_q;
	logic [CNT_W-1:0] ones_q;

	logic                       out_vld_q;
	logic [b58e_pkg::SYM_W-1:0] out_sym_q;
	logic                       out_last_q;

	b58e_pkg::link_t link [DIGIT_DEPTH];
	b58e_pkg::slot_t slot [DIGIT_DEPTH];
	b58e_pkg::link_t head;
	b58e_pkg::ctl_t  ctl;

	logic [DIGIT_DEPTH-1:0] used;
	logic [DIGIT_DEPTH-1:0] tok;
	logic [DIGIT_DEPTH:0]   used_ext;
	logic                   any_tok;
	logic                   top_last;

	logic                       accept;
	logic                       take;
	logic                       can_load;
	logic                       load_out;
	logic [b58e_pkg::SYM_W-1:0] sym_d;
	logic                       last_d;
	logic                       ones_load;
	logic                       ones_dec;
	logic [CNT_W-1:0]           ones_calc;

	assign accept   = s_tvalid && s_tready;
	assign take     = accept && (byte_cnt_q < CNT_W'(MAX_BYTES));
	assign can_load = !out_vld_q || m_tready;

	assign head.vld   = take;
	assign head.carry = b58e_pkg::CARRY_W'(s_tdata);

	for (genvar i = 0; i < DIGIT_DEPTH; i++) begin : g_cell
		b58e_pkg::link_t cin;
		b58e_pkg::slot_t sin;
		if (i == 0) begin : g_base
			assign cin = head;
			assign sin = '0;
		end else begin : g_up
			assign cin = link[i-1];
			assign sin = slot[i-1];
		end
		b58e_cell #(
			.IS_BASE(i == 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.carry_in (cin),
			.carry_out(link[i]),
			.slot_in  (sin),
			.slot_out (slot[i])
		);
		assign used[i] = slot[i].used;
		assign tok[i]  = link[i].vld;
	end

	assign used_ext = {used, 1'b0};
	assign any_tok  = |tok;
	// top cell holds the last digit when the cell just below it is no longer in use
	assign top_last = used[DIGIT_DEPTH-1] && !used_ext[DIGIT_DEPTH-1];

	assign ones_calc = zero_cnt_q - CNT_W'(in_zero_q && (zero_cnt_q != '0));

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		ctl.shift   = 1'b0;
		ctl.restart = 1'b0;
		load_out    = 1'b0;
		sym_d       = b58e_pkg::CHAR_ONE;
		last_d      = 1'b0;
		ones_load   = 1'b0;
		ones_dec    = 1'b0;
		unique case (state_q)
			b58e_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					state_d = b58e_pkg::ST_DRAIN;
				end
			end
			b58e_pkg::ST_DRAIN: begin
				if (!any_tok) begin
					ones_load = 1'b1;
					state_d   = b58e_pkg::ST_ONES;
				end
			end
			b58e_pkg::ST_ONES: begin
				if (ones_q == '0) begin
					state_d = b58e_pkg::ST_DIGITS;
				end else if (can_load) begin
					load_out = 1'b1;
					ones_dec = 1'b1;
				end
			end
			b58e_pkg::ST_DIGITS: begin
				if (used[DIGIT_DEPTH-1]) begin
					if (can_load) begin
						load_out  = 1'b1;
						sym_d     = b58e_pkg::b58_char(slot[DIGIT_DEPTH-1].digit);
						last_d    = top_last;
						ctl.shift = 1'b1;
						if (top_last) begin
							ctl.restart = 1'b1;
							state_d     = b58e_pkg::ST_IDLE;
						end
					end
				end else begin
					// skip empty high cells
					ctl.shift = 1'b1;
				end
			end
			default: begin
				state_d = b58e_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b58e_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			zero_cnt_q <= '0;
			in_zero_q  <= 1'b1;
			ones_q     <= '0;
		end else begin
			if (ones_load) begin
				ones_q     <= ones_calc;
				byte_cnt_q <= '0;
				zero_cnt_q <= '0;
				in_zero_q  <= 1'b1;
			end else if (take) begin
				byte_cnt_q <= byte_cnt_q + CNT_W'(1);
				if (in_zero_q && (s_tdata == 8'h00)) begin
					zero_cnt_q <= zero_cnt_q + CNT_W'(1);
				end else begin
					in_zero_q <= 1'b0;
				end
			end
			if (ones_dec) begin
				ones_q <= ones_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sym_q  <= sym_d;
			out_last_q <= last_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_sym_q};
	assign m_tlast  = out_last_q;

	`B58E_ASSERT_NOW(a_no_wave_in_readout, clk, arst_n, (state_q == b58e_pkg::ST_ONES) || (state_q == b58e_pkg::ST_DIGITS), !any_tok, "carry wave still in flight during readout")
	`B58E_ASSERT_NOW(a_used_contiguous, clk, arst_n, (state_q == b58e_pkg::ST_IDLE) || (state_q == b58e_pkg::ST_DRAIN), used[0] && (((used >> 1) & ~used) == '0), "digit cells in use are not contiguous from the base")
	`B58E_ASSERT_NOW(a_byte_cnt_max, clk, arst_n, 1'b1, byte_cnt_q <= CNT_W'(MAX_BYTES), "byte count beyond maximum")
	`B58E_ASSERT_NOW(a_zero_cnt_le, clk, arst_n, 1'b1, zero_cnt_q <= byte_cnt_q, "zero prefix longer than accepted bytes")

endmodule

@@ rtl/b58e_cell.sv @@
module b58e_cell #(
	parameter bit IS_BASE = 1'b0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  b58e_pkg::ctl_t  ctl,
	input  b58e_pkg::link_t carry_in,
	output b58e_pkg::link_t carry_out,
	input  b58e_pkg::slot_t slot_in,
	output b58e_pkg::slot_t slot_out
);

	logic [b58e_pkg::DIGIT_W-1:0] digit_q;
	logic                         used_q;
	logic [b58e_pkg::CARRY_W-1:0] carry_q;
	logic                         vld_q;

	logic [b58e_pkg::DIGIT_W-1:0] d_eff;
	logic [b58e_pkg::VAL_W-1:0]   v;
	logic [b58e_pkg::PROD_W-1:0]  prod;
	logic [b58e_pkg::CARRY_W-1:0] q;
	logic [b58e_pkg::VAL_W-1:0]   qm;
	logic [b58e_pkg::DIGIT_W-1:0] r;

	// an unused digit reads as zero
	assign d_eff = used_q ? digit_q : '0;

	always_comb begin
		v    = {d_eff, 8'h00} + b58e_pkg::VAL_W'(carry_in.carry);
		prod = b58e_pkg::PROD_W'(v) * b58e_pkg::PROD_W'(b58e_pkg::RECIP);
		q    = prod[b58e_pkg::RECIP_SHIFT +: b58e_pkg::CARRY_W];
		qm   = b58e_pkg::VAL_W'(q) * b58e_pkg::VAL_W'(b58e_pkg::RADIX);
		r    = b58e_pkg::DIGIT_W'(v - qm);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			used_q  <= IS_BASE;
		end else if (ctl.restart) begin
			digit_q <= '0;
			used_q  <= IS_BASE;
		end else if (ctl.shift) begin
			digit_q <= slot_in.digit;
			used_q  <= slot_in.used;
		end else if (carry_in.vld) begin
			digit_q <= r;
			// grow the number while carry remains
			used_q  <= used_q | (carry_in.carry != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= carry_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		carry_q <= q;
	end

	assign carry_out.vld   = vld_q;
	assign carry_out.carry = carry_q;
	assign slot_out.used   = used_q;
	assign slot_out.digit  = d_eff;

endmodule
